>>> rtl/utf8_validating_decoder_macros.svh
// assertion macros for the utf8 validating decoder checker
// no dependencies; included by files that carry concurrent assertions
`ifndef UTF8_VALIDATING_DECODER_MACROS_SVH
`define UTF8_VALIDATING_DECODER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define UVD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("uvd: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define UVD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("uvd: next-cycle check failed");

`endif

>>> rtl/uvd_pkg.sv
// shared types, constants and decode functions for the utf8 validating decoder
// no dependencies
package uvd_pkg;

  // byte classes, assigned when a byte enters the front queue
  typedef enum logic [2:0] {
    CLS_ASCII = 3'd0,
    CLS_CONT  = 3'd1,
    CLS_LEAD2 = 3'd2,
    CLS_LEAD3 = 3'd3,
    CLS_LEAD4 = 3'd4,
    CLS_BAD   = 3'd5
  } byte_class_e;

  localparam logic [7:0] BYTE_ASCII_MAX = 8'h7F;
  localparam logic [7:0] BYTE_CONT_MAX  = 8'hBF;
  localparam logic [7:0] BYTE_LEAD2_MIN = 8'hC2;
  localparam logic [7:0] BYTE_LEAD2_MAX = 8'hDF;
  localparam logic [7:0] BYTE_LEAD3_MAX = 8'hEF;
  localparam logic [7:0] BYTE_LEAD4_MAX = 8'hF4;

  localparam logic [20:0] REPL_CP = 21'h00FFFD;
  localparam logic [20:0] MAX_CP  = 21'h10FFFF;
  localparam logic [20:0] SURR_LO = 21'h00D800;
  localparam logic [20:0] SURR_HI = 21'h00DFFF;
  localparam logic [20:0] FLOOR2  = 21'h000080;
  localparam logic [20:0] FLOOR3  = 21'h000800;
  localparam logic [20:0] FLOOR4  = 21'h010000;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        is_replacement;
    logic        run_end;
    logic        text_end;
  } out_item_t;

  // one buffered byte with its class
  typedef struct packed {
    byte_class_e cls;
    logic [7:0]  value;
  } pend_t;

  typedef pend_t [3:0] pend_vec_t;

  // front queue entry
  typedef struct packed {
    pend_t ent;
    logic  fin;
  } q_ent_t;

  // front queue head as seen by the back end
  typedef struct packed {
    logic   valid;
    q_ent_t head;
  } fq_view_t;

  // one decode decision over the pending buffer
  typedef struct packed {
    logic        emit;
    logic [20:0] cp;
    logic        rep;
    logic [2:0]  drop;
  } dec_t;

  function automatic byte_class_e classify(logic [7:0] b);
    byte_class_e c;
    if (b <= BYTE_ASCII_MAX) c = CLS_ASCII;
    else if (b <= BYTE_CONT_MAX) c = CLS_CONT;
    else if (b < BYTE_LEAD2_MIN) c = CLS_BAD;
    else if (b <= BYTE_LEAD2_MAX) c = CLS_LEAD2;
    else if (b <= BYTE_LEAD3_MAX) c = CLS_LEAD3;
    else if (b <= BYTE_LEAD4_MAX) c = CLS_LEAD4;
    else c = CLS_BAD;
    return c;
  endfunction

  // decide the next result for a buffer holding have bytes
  function automatic dec_t decode(pend_vec_t v, logic [2:0] have, logic fin);
    dec_t        r;
    logic [2:0]  need;
    logic        bad;
    logic [20:0] val;
    logic [20:0] floor_v;
    r.emit  = 1'b0;
    r.cp    = REPL_CP;
    r.rep   = 1'b1;
    r.drop  = 3'd1;
    need    = 3'd0;
    bad     = 1'b0;
    val     = '0;
    floor_v = '0;
    if (have != 3'd0) begin
      unique case (v[0].cls)
        CLS_ASCII: begin
          r.emit = 1'b1;
          r.cp   = {13'd0, v[0].value};
          r.rep  = 1'b0;
        end
        CLS_LEAD2: begin
          need    = 3'd2;
          floor_v = FLOOR2;
          val     = {10'd0, v[0].value[4:0], v[1].value[5:0]};
        end
        CLS_LEAD3: begin
          need    = 3'd3;
          floor_v = FLOOR3;
          val     = {5'd0, v[0].value[3:0], v[1].value[5:0], v[2].value[5:0]};
        end
        CLS_LEAD4: begin
          need    = 3'd4;
          floor_v = FLOOR4;
          val     = {v[0].value[2:0], v[1].value[5:0], v[2].value[5:0], v[3].value[5:0]};
        end
        default: begin
          r.emit = 1'b1;
        end
      endcase
      if (need != 3'd0) begin
        for (int i = 1; i < 4; i++) begin
          if (i < int'(have) && i < int'(need) && v[i].cls != CLS_CONT) bad = 1'b1;
        end
        if (bad) begin
          r.emit = 1'b1;
        end else if (have < need) begin
          // incomplete: wait for more bytes unless the text has ended
          r.emit = fin;
        end else if (val < floor_v || val > MAX_CP || (val >= SURR_LO && val <= SURR_HI)) begin
          r.emit = 1'b1;
        end else begin
          r.emit = 1'b1;
          r.cp   = val;
          r.rep  = 1'b0;
          r.drop = need;
        end
      end
    end
    return r;
  endfunction

  // shift the buffer down by n entries; entries past the count are don't-care
  function automatic pend_vec_t drop_front(pend_vec_t v, logic [2:0] n);
    pend_vec_t r;
    for (int j = 0; j < 4; j++) begin
      r[j] = v[2'(j + int'(n))];
    end
    return r;
  endfunction

endpackage

>>> rtl/uvd_fifo.sv
// small first-word-fall-through queue, flop based
// no package dependencies
module uvd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      if (do_pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/uvd_front.sv
// front end: accepts bytes, classifies them and queues them for the back end
// depends on uvd_pkg and uvd_fifo
module uvd_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  uvd_pkg::in_item_t  in_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output uvd_pkg::fq_view_t  view_o
);

  localparam int unsigned EW = $bits(uvd_pkg::q_ent_t);

  uvd_pkg::q_ent_t wr_ent;
  logic [EW-1:0]   rd_bits;
  logic            q_empty;

  always_comb begin
    wr_ent.ent.cls   = uvd_pkg::classify(in_item_i.byte_value);
    wr_ent.ent.value = in_item_i.byte_value;
    wr_ent.fin       = in_item_i.end_of_text;
  end

  uvd_fifo #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (wr_ent),
    .pop_i  (pop_i),
    .data_o (rd_bits),
    .full_o (full_o),
    .empty_o(q_empty)
  );

  assign view_o.valid = !q_empty;
  assign view_o.head  = uvd_pkg::q_ent_t'(rd_bits);

endmodule

>>> rtl/uvd_back.sv
// back end: pending-byte buffer and decode engine, one result per cycle while the result queue has room
// depends on uvd_pkg
module uvd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  uvd_pkg::fq_view_t  fq_i,
  output logic               pop_o,
  input  logic               out_full_i,
  output logic               out_push_o,
  output uvd_pkg::out_item_t out_item_o
);

  uvd_pkg::pend_vec_t buf_q, buf_d;
  logic [2:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               fin_q, fin_d;

  uvd_pkg::pend_vec_t view_v, rem_v;
  logic [2:0]         view_cnt, rem_cnt;
  logic               view_fin;
  uvd_pkg::dec_t      dec_now, dec_next;
  logic               act, go;

  always_comb begin
    // when not busy the buffer waits for a byte: decode it with the head appended
    view_v   = buf_q;
    view_cnt = cnt_q;
    view_fin = fin_q;
    if (!busy_q) begin
      view_v[cnt_q[1:0]] = fq_i.head.ent;
      view_cnt           = cnt_q + 3'd1;
      view_fin           = fq_i.head.fin;
    end

    dec_now  = uvd_pkg::decode(view_v, view_cnt, view_fin);
    rem_v    = uvd_pkg::drop_front(view_v, dec_now.drop);
    rem_cnt  = view_cnt - dec_now.drop;
    // look ahead: does what is left give another result now
    dec_next = uvd_pkg::decode(rem_v, rem_cnt, view_fin);

    act = busy_q || fq_i.valid;
    go  = act && (!dec_now.emit || !out_full_i);

    buf_d  = buf_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    fin_d  = fin_q;
    if (go) begin
      if (dec_now.emit) begin
        buf_d  = rem_v;
        cnt_d  = rem_cnt;
        busy_d = dec_next.emit;
      end else begin
        buf_d  = view_v;
        cnt_d  = view_cnt;
        busy_d = 1'b0;
      end
      fin_d = view_fin;
    end

    pop_o                     = go && !busy_q;
    out_push_o                = go && dec_now.emit;
    out_item_o.code_point     = dec_now.cp;
    out_item_o.is_replacement = dec_now.rep;
    out_item_o.run_end        = !dec_next.emit;
    out_item_o.text_end       = !dec_next.emit && view_fin;
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      fin_q  <= fin_d;
    end
  end

endmodule

>>> rtl/utf8_validating_decoder.sv
// top level of the utf8 validating decoder
// depends on uvd_pkg, uvd_front, uvd_back and uvd_fifo
//
// usage
// - input channel: drive in_item_i and raise push; a byte transfers on a rising
//   edge with push high and full low. end_of_text marks the last byte of a text
// - result channel: while empty is low the oldest code point is on out_item_o;
//   it transfers on a rising edge with pop high and empty low
// - path: a byte that completes a character is held in the front queue, then
//   the engine decodes it and its result is registered in the result queue
// - throughput: while the result queue has room, the decode engine makes one
//   result per cycle, so one byte per cycle while each byte yields at most one
//   result; a byte yielding more (replays after an error or a cut text) holds
//   the engine till done; the front queue absorbs IN_DEPTH bytes before full rises
// - reset: both queues empty and the pending-byte buffer empty; no clearing pass
// - receiver stall: the result queue buffers OUT_DEPTH results, then the engine
//   waits, then the front queue fills and full rises; nothing is dropped
module utf8_validating_decoder #(
  parameter int unsigned IN_DEPTH  = 2,  // front queue entries, 2 or more
  parameter int unsigned OUT_DEPTH = 4   // result queue entries, 2 or more
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  uvd_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output uvd_pkg::out_item_t out_item_o
);

  localparam int unsigned OW = $bits(uvd_pkg::out_item_t);

  uvd_pkg::fq_view_t  fq_view;      // head of the front queue
  logic               fq_pop;       // engine consumes the head byte
  logic               res_full;     // result queue cannot take a transfer
  logic               res_push;     // engine produces a result
  uvd_pkg::out_item_t res_item;
  logic [OW-1:0]      res_bits;

  // front: classify each byte and queue it
  uvd_front #(
    .DEPTH(IN_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .in_item_i(in_item_i),
    .full_o   (full),
    .pop_i    (fq_pop),
    .view_o   (fq_view)
  );

  // back: pending buffer and one decode decision per cycle unless res_full stalls it
  uvd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fq_i      (fq_view),
    .pop_o     (fq_pop),
    .out_full_i(res_full),
    .out_push_o(res_push),
    .out_item_o(res_item)
  );

  // result queue decouples the engine from a stalling receiver
  uvd_fifo #(
    .WIDTH(OW),
    .DEPTH(OUT_DEPTH)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_item),
    .pop_i  (pop),
    .data_o (res_bits),
    .full_o (res_full),
    .empty_o(empty)
  );

  assign out_item_o = uvd_pkg::out_item_t'(res_bits);

endmodule

>>> rtl/uvd_checker.sv
// port-level checks for the utf8 validating decoder, bound to the top level
// depends on uvd_pkg and utf8_validating_decoder_macros.svh
`include "utf8_validating_decoder_macros.svh"

module uvd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input uvd_pkg::out_item_t out_item_o
);

  // end of text always closes the run of the byte that caused it
  `UVD_ASSERT_SAME(a_text_end_closes_run, clk_i, rst_ni, !empty && out_item_o.text_end, out_item_o.run_end)

  // a substituted result carries the replacement character
  `UVD_ASSERT_SAME(a_repl_value, clk_i, rst_ni, !empty && out_item_o.is_replacement, out_item_o.code_point == uvd_pkg::REPL_CP)

  // a decoded result is a scalar value: in range and not a surrogate
  `UVD_ASSERT_SAME(a_scalar_value, clk_i, rst_ni, !empty && !out_item_o.is_replacement, out_item_o.code_point <= uvd_pkg::MAX_CP && (out_item_o.code_point < uvd_pkg::SURR_LO || out_item_o.code_point > uvd_pkg::SURR_HI))

  // a waiting result stays put until it transfers
  `UVD_ASSERT_NEXT(a_result_held, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_item_o))

endmodule

bind utf8_validating_decoder uvd_checker u_uvd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .empty     (empty),
  .pop       (pop),
  .out_item_o(out_item_o)
);
